>>> src/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared beat types and register map of the two-level inclusive LRU cache.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int LAT_W      = 10;

  localparam logic [1:0] REG_MEM_LAT  = 2'd0;
  localparam logic [1:0] REG_L1_LAT   = 2'd1;
  localparam logic [1:0] REG_L2_LAT   = 2'd2;
  localparam logic [1:0] REG_WR_ALLOC = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic        first_level_hit;
    logic        second_level_hit;
    logic [11:0] access_latency;
    logic [31:0] access_total;
    logic [31:0] first_hit_total;
    logic [31:0] second_hit_total;
    logic [47:0] cycle_total;
  } out_t;

endpackage

>>> src/tlc_set_ctl.sv
// ----------------------------------------------------------------------------
// tlc_set_ctl
// Per-set lookup, fill way selection and true-LRU rank update for one row.
// ----------------------------------------------------------------------------
module tlc_set_ctl
  import tlc_pkg::*;
#(
  parameter int WAY_BITS = 1,
  parameter int TAG_W    = 24,
  localparam int WAYS    = 1 << WAY_BITS,
  localparam int RW      = (WAY_BITS > 0) ? WAY_BITS : 1
) (
  input  logic [WAYS-1:0][TAG_W-1:0] tags,
  input  logic [WAYS-1:0]            valid,
  input  logic [WAYS-1:0][RW-1:0]    rank,
  input  logic [TAG_W-1:0]           key,
  input  logic [RW-1:0]              sel_way,
  output logic                       hit,
  output logic [RW-1:0]              hit_way,
  output logic [RW-1:0]              fill_way,
  output logic                       full,
  output logic [WAYS-1:0][RW-1:0]    rank_upd
);

  logic          found_inv;
  logic          found_lru;
  logic [RW-1:0] old_rank;

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    found_inv = 1'b0;
    found_lru = 1'b0;
    fill_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && valid[w] && tags[w] == key) begin
        hit     = 1'b1;
        hit_way = RW'(w);
      end
    end
    full = &valid;
    for (int w = 0; w < WAYS; w++) begin
      if (!found_inv && !valid[w]) begin
        found_inv = 1'b1;
        fill_way  = RW'(w);
      end
    end
    if (full) begin
      for (int w = 0; w < WAYS; w++) begin
        if (!found_lru && rank[w] == '0) begin
          found_lru = 1'b1;
          fill_way  = RW'(w);
        end
      end
    end
  end

  always_comb begin
    old_rank = rank[sel_way];
    for (int w = 0; w < WAYS; w++) begin
      if (RW'(w) == sel_way) begin
        rank_upd[w] = RW'(WAYS - 1);
      end else if (rank[w] > old_rank) begin
        rank_upd[w] = rank[w] - RW'(1);
      end else begin
        rank_upd[w] = rank[w];
      end
    end
  end

endmodule

>>> src/two_level_inclusive_lru_cache_unit.sv
// ----------------------------------------------------------------------------
// two_level_inclusive_lru_cache_unit
// Inclusive L1/L2 set-associative cache model with true LRU and counters.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------
//  in        | start & !busy              | in_data  (in_t)
//  out       | out_valid, one cycle       | out_data (out_t)
//  cfg       | psel & penable & pwrite    | paddr / pwdata / prdata
//
// A near hit passes through LOOK and DONE; a far hit with fill adds NFILL, and
// WB when the near victim is dirty; a full miss may add BINV and NRD as well
// (far evict, near back-invalidate, near refill, far writeback), each step a
// registered read of a row memory followed by a write back.
// Sync reset clears state, init flags and counters; no clearing pass.
// Results cannot be stalled; busy drops with the result beat.
// ----------------------------------------------------------------------------
module two_level_inclusive_lru_cache_unit
  import tlc_pkg::*;
#(
  parameter int ADDR_BITS         = 32,
  parameter int BLOCK_OFFSET_BITS = 4,
  parameter int NEAR_SET_BITS     = 4,
  parameter int NEAR_WAY_BITS     = 1,
  parameter int FAR_SET_BITS      = 6,
  parameter int FAR_WAY_BITS      = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_data,
  output logic                  out_valid,
  output out_t                  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int AW    = ADDR_BITS;
  localparam int OFF   = BLOCK_OFFSET_BITS;
  localparam int NSB   = NEAR_SET_BITS;
  localparam int FSB   = FAR_SET_BITS;
  localparam int NWAYS = 1 << NEAR_WAY_BITS;
  localparam int FWAYS = 1 << FAR_WAY_BITS;
  localparam int NRW   = (NEAR_WAY_BITS > 0) ? NEAR_WAY_BITS : 1;
  localparam int FRW   = (FAR_WAY_BITS > 0) ? FAR_WAY_BITS : 1;
  localparam int NSW   = (NSB > 0) ? NSB : 1;
  localparam int FSW   = (FSB > 0) ? FSB : 1;
  localparam int NSETS = 1 << NSW;
  localparam int FSETS = 1 << FSW;
  localparam int NTW   = AW - OFF - NSB;
  localparam int FTW   = AW - OFF - FSB;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_BINV  = 3'd2;
  localparam logic [2:0] S_NRD   = 3'd3;
  localparam logic [2:0] S_NFILL = 3'd4;
  localparam logic [2:0] S_WB    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  typedef struct packed {
    logic [NWAYS-1:0][NTW-1:0] tag;
    logic [NWAYS-1:0]          valid;
    logic [NWAYS-1:0]          dirty;
    logic [NWAYS-1:0][NRW-1:0] rank;
  } near_row_t;

  typedef struct packed {
    logic [FWAYS-1:0][FTW-1:0] tag;
    logic [FWAYS-1:0]          valid;
    logic [FWAYS-1:0]          dirty;
    logic [FWAYS-1:0][FRW-1:0] rank;
  } far_row_t;

  function automatic logic [NSW-1:0] nset_of(input logic [AW-1:0] a);
    return NSW'((a >> OFF) & ((AW'(1) << NSB) - AW'(1)));
  endfunction

  function automatic logic [FSW-1:0] fset_of(input logic [AW-1:0] a);
    return FSW'((a >> OFF) & ((AW'(1) << FSB) - AW'(1)));
  endfunction

  function automatic logic [NTW-1:0] ntag_of(input logic [AW-1:0] a);
    return NTW'(a >> (OFF + NSB));
  endfunction

  function automatic logic [FTW-1:0] ftag_of(input logic [AW-1:0] a);
    return FTW'(a >> (OFF + FSB));
  endfunction

  function automatic logic [AW-1:0] nrebuild(input logic [NSW-1:0] s,
                                             input logic [NTW-1:0] t);
    return (AW'(t) << (OFF + NSB)) | (AW'(s) << OFF);
  endfunction

  function automatic logic [AW-1:0] frebuild(input logic [FSW-1:0] s,
                                             input logic [FTW-1:0] t);
    return (AW'(t) << (OFF + FSB)) | (AW'(s) << OFF);
  endfunction

  // config
  logic [LAT_W-1:0] mem_lat_r, l1_lat_r, l2_lat_r;
  logic             wr_alloc_r;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_lat_r  <= LAT_W'(100);
      l1_lat_r   <= LAT_W'(1);
      l2_lat_r   <= LAT_W'(5);
      wr_alloc_r <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MEM_LAT:  mem_lat_r  <= pwdata[LAT_W-1:0];
        REG_L1_LAT:   l1_lat_r   <= pwdata[LAT_W-1:0];
        REG_L2_LAT:   l2_lat_r   <= pwdata[LAT_W-1:0];
        REG_WR_ALLOC: wr_alloc_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MEM_LAT:  prdata = 32'(mem_lat_r);
      REG_L1_LAT:   prdata = 32'(l1_lat_r);
      REG_L2_LAT:   prdata = 32'(l2_lat_r);
      REG_WR_ALLOC: prdata = 32'(wr_alloc_r);
      default:      prdata = '0;
    endcase
  end

  // row memories
  near_row_t near_mem [NSETS];
  far_row_t  far_mem  [FSETS];
  near_row_t near_q_r, near_row, near_wd;
  far_row_t  far_q_r, far_row, far_wd;
  logic      near_re, near_we, far_re, far_we;
  logic [NSW-1:0] near_ra, near_wa;
  logic [FSW-1:0] far_ra, far_wa;
  logic [NSETS-1:0] near_init_r;
  logic [FSETS-1:0] far_init_r;
  logic near_iq_r, far_iq_r;

  always_ff @(posedge clk) begin
    if (near_we) near_mem[near_wa] <= near_wd;
    if (near_re) near_q_r <= near_mem[near_ra];
    if (far_we) far_mem[far_wa] <= far_wd;
    if (far_re) far_q_r <= far_mem[far_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_init_r <= '0;
      far_init_r  <= '0;
      near_iq_r   <= 1'b0;
      far_iq_r    <= 1'b0;
    end else begin
      if (near_we) near_init_r[near_wa] <= 1'b1;
      if (far_we) far_init_r[far_wa] <= 1'b1;
      if (near_re) near_iq_r <= near_init_r[near_ra];
      if (far_re) far_iq_r <= far_init_r[far_ra];
    end
  end

  always_comb begin
    near_row = near_q_r;
    if (!near_iq_r) begin
      near_row.valid = '0;
      near_row.dirty = '0;
      for (int w = 0; w < NWAYS; w++) near_row.rank[w] = NRW'(w);
    end
    far_row = far_q_r;
    if (!far_iq_r) begin
      far_row.valid = '0;
      far_row.dirty = '0;
      for (int w = 0; w < FWAYS; w++) far_row.rank[w] = FRW'(w);
    end
  end

  // control
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] a_r, a_nxt, va_r, va_nxt, nva_r, nva_nxt;
  logic          wr_r, wr_nxt;
  logic          h1_r, h1_nxt, h2_r, h2_nxt;
  logic [11:0]   lat_r, lat_nxt;
  logic          fill;
  logic [31:0]   acc_cnt_r, h1_cnt_r, h2_cnt_r;
  logic [47:0]   cyc_cnt_r;
  logic          out_valid_r;
  out_t          out_data_r;

  logic [NTW-1:0] n_key;
  logic [NRW-1:0] n_sel, n_hw, n_fw;
  logic           n_hit, n_full;
  logic [NWAYS-1:0][NRW-1:0] n_rank_upd;
  logic [FTW-1:0] f_key;
  logic [FRW-1:0] f_sel, f_hw, f_fw;
  logic           f_hit, f_full;
  logic [FWAYS-1:0][FRW-1:0] f_rank_upd;

  assign n_key = (state_r == S_BINV) ? ntag_of(va_r) : ntag_of(a_r);
  assign n_sel = (state_r == S_NFILL) ? n_fw : n_hw;
  assign f_key = (state_r == S_WB) ? ftag_of(nva_r) : ftag_of(a_r);
  assign f_sel = (state_r == S_LOOK && !f_hit) ? f_fw : f_hw;
  assign fill  = !wr_r || wr_alloc_r;

  tlc_set_ctl #(.WAY_BITS(NEAR_WAY_BITS), .TAG_W(NTW)) u_near_ctl (
    .tags(near_row.tag), .valid(near_row.valid), .rank(near_row.rank),
    .key(n_key), .sel_way(n_sel), .hit(n_hit), .hit_way(n_hw),
    .fill_way(n_fw), .full(n_full), .rank_upd(n_rank_upd)
  );

  tlc_set_ctl #(.WAY_BITS(FAR_WAY_BITS), .TAG_W(FTW)) u_far_ctl (
    .tags(far_row.tag), .valid(far_row.valid), .rank(far_row.rank),
    .key(f_key), .sel_way(f_sel), .hit(f_hit), .hit_way(f_hw),
    .fill_way(f_fw), .full(f_full), .rank_upd(f_rank_upd)
  );

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    wr_nxt    = wr_r;
    va_nxt    = va_r;
    nva_nxt   = nva_r;
    h1_nxt    = h1_r;
    h2_nxt    = h2_r;
    lat_nxt   = lat_r;
    near_re   = 1'b0;
    near_we   = 1'b0;
    near_ra   = nset_of(a_r);
    near_wa   = nset_of(a_r);
    near_wd   = near_row;
    far_re    = 1'b0;
    far_we    = 1'b0;
    far_ra    = fset_of(a_r);
    far_wa    = fset_of(a_r);
    far_wd    = far_row;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          a_nxt     = AW'(in_data.address);
          wr_nxt    = in_data.mode;
          near_re   = 1'b1;
          near_ra   = nset_of(a_nxt);
          far_re    = 1'b1;
          far_ra    = fset_of(a_nxt);
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        h1_nxt  = n_hit;
        h2_nxt  = !n_hit && f_hit;
        lat_nxt = 12'(l1_lat_r) + (n_hit ? 12'd0 : 12'(l2_lat_r))
                  + ((n_hit || f_hit) ? 12'd0 : 12'(mem_lat_r));
        if (n_hit) begin
          near_we      = 1'b1;
          near_wd.rank = n_rank_upd;
          if (wr_r) near_wd.dirty[n_hw] = 1'b1;
          state_nxt    = S_DONE;
        end else if (f_hit) begin
          far_we      = 1'b1;
          far_wd.rank = f_rank_upd;
          if (wr_r) far_wd.dirty[f_hw] = 1'b1;
          state_nxt   = fill ? S_NFILL : S_DONE;
        end else if (fill) begin
          far_we             = 1'b1;
          far_wd.tag[f_fw]   = ftag_of(a_r);
          far_wd.valid[f_fw] = 1'b1;
          far_wd.dirty[f_fw] = wr_r;
          far_wd.rank        = f_rank_upd;
          if (f_full) begin
            va_nxt    = frebuild(fset_of(a_r), far_row.tag[f_fw]);
            near_re   = 1'b1;
            near_ra   = nset_of(va_nxt);
            state_nxt = S_BINV;
          end else begin
            state_nxt = S_NFILL;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_BINV: begin
        near_wa = nset_of(va_r);
        if (n_hit) begin
          near_we             = 1'b1;
          near_wd.valid[n_hw] = 1'b0;
        end
        state_nxt = S_NRD;
      end
      S_NRD: begin
        near_re   = 1'b1;
        state_nxt = S_NFILL;
      end
      S_NFILL: begin
        near_we             = 1'b1;
        near_wd.tag[n_fw]   = ntag_of(a_r);
        near_wd.valid[n_fw] = 1'b1;
        near_wd.dirty[n_fw] = wr_r;
        near_wd.rank        = n_rank_upd;
        if (n_full && near_row.dirty[n_fw]) begin
          nva_nxt   = nrebuild(nset_of(a_r), near_row.tag[n_fw]);
          far_re    = 1'b1;
          far_ra    = fset_of(nva_nxt);
          state_nxt = S_WB;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WB: begin
        far_wa = fset_of(nva_r);
        if (f_hit) begin
          far_we             = 1'b1;
          far_wd.dirty[f_hw] = 1'b1;
          far_wd.rank        = f_rank_upd;
        end
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    wr_r  <= wr_nxt;
    va_r  <= va_nxt;
    nva_r <= nva_nxt;
    h1_r  <= h1_nxt;
    h2_r  <= h2_nxt;
    lat_r <= lat_nxt;
    if (state_r == S_DONE) begin
      out_data_r.first_level_hit  <= h1_r;
      out_data_r.second_level_hit <= h2_r;
      out_data_r.access_latency   <= lat_r;
      out_data_r.access_total     <= acc_cnt_r + 32'd1;
      out_data_r.first_hit_total  <= h1_cnt_r + 32'(h1_r);
      out_data_r.second_hit_total <= h2_cnt_r + 32'(h2_r);
      out_data_r.cycle_total      <= cyc_cnt_r + 48'(lat_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      acc_cnt_r   <= '0;
      h1_cnt_r    <= '0;
      h2_cnt_r    <= '0;
      cyc_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_DONE);
      if (state_r == S_DONE) begin
        acc_cnt_r <= acc_cnt_r + 32'd1;
        h1_cnt_r  <= h1_cnt_r + 32'(h1_r);
        h2_cnt_r  <= h2_cnt_r + 32'(h2_r);
        cyc_cnt_r <= cyc_cnt_r + 48'(lat_r);
      end
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE))
    else $error("result beat without finished access");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && state_r == S_LOOK))
    else $error("accepted access did not start lookup");

  a_hit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.first_level_hit && out_data.second_level_hit))
    else $error("both hit levels flagged");

endmodule

>>> test/tb_two_level_inclusive_lru_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_level_inclusive_lru_cache_unit
// Self-checking bench for the inclusive L1/L2 LRU cache unit. A queue-fed
// driver issues read/write beats in random bursts; a cache shadow predicts hit
// level, latency and running totals per beat, and a monitor compares every
// result beat field by field. Several latency/allocation settings are
// programmed over the APB port between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_two_level_inclusive_lru_cache_unit;
  import tlc_pkg::*;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct {
    bit  drain;
    in_t beat;
  } pend_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  two_level_inclusive_lru_cache_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // cache shadow
  logic [23:0] l1_tag [32];
  bit          l1_val [32];
  bit          l1_dirty [32];
  bit          l1_rank [32];
  logic [21:0] l2_tag [256];
  bit          l2_val [256];
  bit          l2_dirty [256];
  logic [1:0]  l2_rank [256];
  logic [31:0] n_acc, n_l1hit, n_l2hit;
  logic [47:0] n_cyc;
  logic [9:0]  mem_lat = 10'd100, l1_lat = 10'd1, l2_lat = 10'd5;
  bit          wr_alloc = 1'b1;

  pend_t pending[$];
  out_t  expected_results[$];
  int    errors = 0;
  int    burst_left = 4, gap_left = 0;

  initial begin
    for (int i = 0; i < 32; i++) begin
      l1_tag[i] = '0; l1_val[i] = 0; l1_dirty[i] = 0; l1_rank[i] = i % 2;
    end
    for (int i = 0; i < 256; i++) begin
      l2_tag[i] = '0; l2_val[i] = 0; l2_dirty[i] = 0; l2_rank[i] = i % 4;
    end
    n_acc = '0; n_l1hit = '0; n_l2hit = '0; n_cyc = '0;
  end

  function automatic int l1_find(logic [31:0] a);
    for (int w = 0; w < 2; w++)
      if (l1_val[a[7:4]*2+w] && l1_tag[a[7:4]*2+w] == a[31:8]) return w;
    return -1;
  endfunction

  function automatic int l2_find(logic [31:0] a);
    for (int w = 0; w < 4; w++)
      if (l2_val[a[9:4]*4+w] && l2_tag[a[9:4]*4+w] == a[31:10]) return w;
    return -1;
  endfunction

  function automatic void l1_touch(int s, int way);
    bit old;
    old = l1_rank[s*2+way];
    l1_rank[s*2+way] = 1'b1;
    for (int w = 0; w < 2; w++)
      if (w != way && l1_rank[s*2+w] > old) l1_rank[s*2+w]--;
  endfunction

  function automatic void l2_touch(int s, int way);
    logic [1:0] old;
    old = l2_rank[s*4+way];
    l2_rank[s*4+way] = 2'd3;
    for (int w = 0; w < 4; w++)
      if (w != way && l2_rank[s*4+w] > old) l2_rank[s*4+w]--;
  endfunction

  // returns line index of new far line
  function automatic int l2_alloc(logic [31:0] a);
    int s, way, nw;
    logic [31:0] va;
    s = a[9:4];
    way = -1;
    for (int w = 0; w < 4; w++) if (way < 0 && !l2_val[s*4+w]) way = w;
    if (way < 0) begin
      way = 0;
      for (int w = 3; w >= 0; w--) if (l2_rank[s*4+w] == 0) way = w;
      va = {l2_tag[s*4+way], a[9:4], 4'b0};
      nw = l1_find(va);
      if (nw >= 0) l1_val[va[7:4]*2+nw] = 0;
    end
    l2_tag[s*4+way] = a[31:10]; l2_val[s*4+way] = 1; l2_dirty[s*4+way] = 0;
    l2_touch(s, way);
    return s*4+way;
  endfunction

  function automatic int l1_alloc(logic [31:0] a);
    int s, way, fw;
    logic [31:0] va;
    s = a[7:4];
    way = -1;
    for (int w = 0; w < 2; w++) if (way < 0 && !l1_val[s*2+w]) way = w;
    if (way < 0) begin
      way = l1_rank[s*2] == 0 ? 0 : 1;
      if (l1_dirty[s*2+way]) begin
        va = {l1_tag[s*2+way], a[7:4], 4'b0};
        fw = l2_find(va);
        if (fw >= 0) begin
          l2_dirty[va[9:4]*4+fw] = 1;
          l2_touch(va[9:4], fw);
        end
      end
    end
    l1_tag[s*2+way] = a[31:8]; l1_val[s*2+way] = 1; l1_dirty[s*2+way] = 0;
    l1_touch(s, way);
    return s*2+way;
  endfunction

  function automatic out_t predict_access(in_t b);
    out_t r;
    int nw, fw, ni, fi;
    logic [11:0] lat;
    bit wr;
    wr = b.mode == MODE_WRITE;
    nw = l1_find(b.address);
    fw = l2_find(b.address);
    lat = l1_lat;
    r = '0;
    if (nw >= 0) begin
      r.first_level_hit = 1;
      l1_touch(b.address[7:4], nw);
      if (wr) l1_dirty[b.address[7:4]*2+nw] = 1;
    end else if (fw >= 0) begin
      r.second_level_hit = 1;
      lat += l2_lat;
      l2_touch(b.address[9:4], fw);
      if (wr) l2_dirty[b.address[9:4]*4+fw] = 1;
      if (!wr || wr_alloc) begin
        ni = l1_alloc(b.address);
        if (wr) l1_dirty[ni] = 1;
      end
    end else begin
      lat += l2_lat + mem_lat;
      if (!wr || wr_alloc) begin
        fi = l2_alloc(b.address);
        ni = l1_alloc(b.address);
        if (wr) begin
          l2_dirty[fi] = 1; l1_dirty[ni] = 1;
        end
      end
    end
    n_acc++;
    n_l1hit += r.first_level_hit;
    n_l2hit += r.second_level_hit;
    n_cyc += lat;
    r.access_latency = lat;
    r.access_total = n_acc;
    r.first_hit_total = n_l1hit;
    r.second_hit_total = n_l2hit;
    r.cycle_total = n_cyc;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_results.push_back(predict_access(in_data));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending.size() > 0 && pending[0].drain) begin
          start <= 1'b0;
          if (expected_results.size() == 0 && !(start && !busy)) void'(pending.pop_front());
        end else if (pending.size() > 0) begin
          start <= 1'b1;
          in_data <= pending.pop_front().beat;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        e = expected_results.pop_front();
        if (out_data.first_level_hit !== e.first_level_hit ||
            out_data.second_level_hit !== e.second_level_hit ||
            out_data.access_latency !== e.access_latency ||
            out_data.access_total !== e.access_total ||
            out_data.first_hit_total !== e.first_hit_total ||
            out_data.second_hit_total !== e.second_hit_total ||
            out_data.cycle_total !== e.cycle_total) begin
          errors++;
          if (errors <= 10) $display("mismatch: exp %p got %p", e, out_data);
        end
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MEM_LAT:  mem_lat = val[9:0];
      REG_L1_LAT:   l1_lat = val[9:0];
      REG_L2_LAT:   l2_lat = val[9:0];
      REG_WR_ALLOC: wr_alloc = val[0];
    endcase
  endtask

  task automatic queue_beat(logic m, logic [31:0] a);
    pend_t p;
    p.drain = 0;
    p.beat.mode = m;
    p.beat.address = a;
    pending.push_back(p);
  endtask

  task automatic queue_drain();
    pend_t p;
    p.drain = 1;
    p.beat = '0;
    pending.push_back(p);
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || expected_results.size() > 0 || start || busy)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    logic [21:0] hi [12];
    logic [31:0] a;
    for (int i = 0; i < 12; i++) hi[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom;
      end else begin
        a = {hi[$urandom_range(0, 11)], 6'd0, 4'($urandom)};
        a[9:4] = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
      end
      queue_beat($urandom_range(0, 2) == 0 ? MODE_WRITE : MODE_READ, a);
      if (i == n / 2) queue_drain();
    end
  endtask

  initial begin
    logic [31:0] a;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, hits at both levels, dirty near victim, far eviction
    queue_beat(MODE_READ, 32'h0000_0000);
    queue_beat(MODE_READ, 32'h0000_000F);
    queue_beat(MODE_WRITE, 32'hFFFF_FFFF);
    queue_beat(MODE_READ, 32'hFFFF_FFF0);
    queue_beat(MODE_WRITE, 32'h0000_0100);
    queue_beat(MODE_WRITE, 32'h0000_0200);
    queue_beat(MODE_READ, 32'h0000_0000);
    queue_beat(MODE_READ, 32'h0000_0100);
    for (int i = 1; i <= 5; i++) queue_beat(i % 2 ? MODE_WRITE : MODE_READ, i << 10);
    queue_beat(MODE_READ, 32'h0000_0400);
    queue_beat(MODE_WRITE, 32'h0000_0800);
    queue_beat(MODE_READ, 32'h0000_0000);
    queue_drain();
    queue_random(330);
    wait_idle();
    cfg_write(REG_MEM_LAT, 32'd0);
    cfg_write(REG_L1_LAT, 32'd0);
    cfg_write(REG_L2_LAT, 32'd0);
    cfg_write(REG_WR_ALLOC, 32'd0);
    for (int i = 0; i < 6; i++) begin
      a = 32'h0000_3000 + (i << 10);
      queue_beat(MODE_WRITE, a);
      queue_beat(MODE_READ, a);
      queue_beat(MODE_WRITE, a);
    end
    queue_random(330);
    wait_idle();
    cfg_write(REG_MEM_LAT, 32'hFFFF_FFFF);
    cfg_write(REG_L1_LAT, 32'd1023);
    cfg_write(REG_L2_LAT, 32'd1023);
    cfg_write(REG_WR_ALLOC, 32'd1);
    queue_random(350);
    wait_idle();
    cfg_write(REG_MEM_LAT, $urandom_range(0, 1023));
    cfg_write(REG_L1_LAT, $urandom_range(0, 1023));
    cfg_write(REG_L2_LAT, $urandom_range(0, 1023));
    cfg_write(REG_WR_ALLOC, $urandom_range(0, 1));
    queue_random(350);
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #3ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
src/tlc_pkg.sv
src/tlc_set_ctl.sv
src/two_level_inclusive_lru_cache_unit.sv
test/tb_two_level_inclusive_lru_cache_unit.sv
